>>> rtl/dithered_gradient_bevel_generator_unit_defines.svh
// assertion macros for the gradient bevel generator
// used by the top level only; empty bodies when SYNTHESIS is defined
`ifndef DITHERED_GRADIENT_BEVEL_GENERATOR_UNIT_DEFINES_SVH
`define DITHERED_GRADIENT_BEVEL_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define DGBG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dgbg assertion failed");
`define DGBG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dgbg assertion failed");
`else
`define DGBG_ASSERT_IMP(label, clk, rst, ante, cons)
`define DGBG_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/dgbg_pkg.sv
// shared types, constants and helper functions of the gradient bevel generator
// no dependencies
package dgbg_pkg;

   localparam int COLOR_W = 48;
   localparam int ROWS_W  = 11;
   localparam int FLAGS_W = 4;
   localparam int CSR_W   = 64;
   localparam int CSR_AW  = 5;

   localparam logic [31:0]        LCG_MUL    = 32'd1664525;
   localparam logic [31:0]        LCG_ADD    = 32'd1013904223;
   localparam logic [7:0]         BEVEL      = 8'd32;
   localparam logic [ROWS_W-1:0]  ROWS_RESET = 11'd1;

   localparam int FLAG_TOP    = 0;
   localparam int FLAG_BOTTOM = 1;
   localparam int FLAG_LEFT   = 2;
   localparam int FLAG_RIGHT  = 3;

   typedef enum logic [1:0] {
      CSR_START_COLOR = 2'd0,
      CSR_END_COLOR   = 2'd1,
      CSR_ROWS        = 2'd2,
      CSR_BEVEL_FLAGS = 2'd3
   } csr_index_type;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_START   = 10'b00_0000_0010,
      ST_LMUL    = 10'b00_0000_0100,
      ST_LDIVINI = 10'b00_0000_1000,
      ST_LDIV    = 10'b00_0001_0000,
      ST_LSTORE  = 10'b00_0010_0000,
      ST_DISSUE  = 10'b00_0100_0000,
      ST_DWB     = 10'b00_1000_0000,
      ST_RISSUE  = 10'b01_0000_0000,
      ST_DONE    = 10'b10_0000_0000
   } state_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } mul_req_type;

   function automatic logic [7:0] sat_add(input logic [7:0] v);
      logic [8:0] s;
      s = {1'b0, v} + {1'b0, BEVEL};
      return s[8] ? 8'hff : s[7:0];
   endfunction

   function automatic logic [7:0] sat_sub(input logic [7:0] v);
      return (v < BEVEL) ? 8'h00 : v - BEVEL;
   endfunction

   function automatic logic [7:0] dither_byte(input logic [15:0] ch, input logic [7:0] nz);
      logic [16:0] s;
      s = {1'b0, ch} + {9'd0, nz};
      return s[16] ? 8'hff : s[15:8];
   endfunction

endpackage

>>> rtl/dgbg_mul.sv
// shared multiply-add unit: registered low 32 bits of a * b + c
// depends on dgbg_pkg
module dgbg_mul (
   input  logic                clock,
   input  dgbg_pkg::mul_req_type req,
   output logic [31:0]         product
);

   logic [31:0] prod_ff;
   logic [31:0] prod_in;

   assign prod_in = req.a * req.b + req.c;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

>>> rtl/dithered_gradient_bevel_generator_unit.sv
// dithered vertical gradient pixel generator with bevel tile variants
// at a row start the sequencer first runs three lerps (each one multiply and a 16-step divide),
//   then dithers each channel; at a row end it adds a step for the row noise
// a new transaction is accepted only once the last one has left the sequencer; the pace is
//   set by the shared 32-bit multiply-add unit and the one-bit-per-cycle divider
// reset: synchronous, clears sequencer, counters, noise, configuration, channels and rsp_valid; data regs keep
`include "dithered_gradient_bevel_generator_unit_defines.svh"
module dithered_gradient_bevel_generator_unit #(
   parameter int ROW_PIXELS = 16,
   parameter int MAX_ROWS   = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_frame_start,
   input  logic [31:0]                 req_seed,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_mid_blue,
   output logic [7:0]                  rsp_mid_green,
   output logic [7:0]                  rsp_mid_red,
   output logic [7:0]                  rsp_left_blue,
   output logic [7:0]                  rsp_left_green,
   output logic [7:0]                  rsp_left_red,
   output logic [7:0]                  rsp_right_blue,
   output logic [7:0]                  rsp_right_green,
   output logic [7:0]                  rsp_right_red,
   output logic                        rsp_row_end,
   output logic                        rsp_frame_end,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [dgbg_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [dgbg_pkg::CSR_W-1:0]  csr_pwdata,
   output logic [dgbg_pkg::CSR_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   localparam int CW = (ROW_PIXELS > 1) ? $clog2(ROW_PIXELS) : 1;
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int HW = $clog2(MAX_ROWS + 1);
   localparam int EW = (HW > dgbg_pkg::ROWS_W) ? HW : dgbg_pkg::ROWS_W;

   // configuration
   logic [dgbg_pkg::COLOR_W-1:0] start_color_ff, start_color_in;
   logic [dgbg_pkg::COLOR_W-1:0] end_color_ff, end_color_in;
   logic [dgbg_pkg::ROWS_W-1:0]  rows_ff, rows_in;
   logic [dgbg_pkg::FLAGS_W-1:0] flags_ff, flags_in;

   // sequencer and state
   dgbg_pkg::state_type state_ff, state_in;
   logic [1:0]       ch_ff, ch_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [CW-1:0]    column_ff, column_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [31:0]      noise_ff, noise_in;
   logic [31:0]      rnoise_ff, rnoise_in;
   logic [2:0][15:0] chan_ff, chan_in;
   logic [2:0][7:0]  byte_ff, byte_in;
   logic [15:0]      rem_ff, rem_in;
   logic [15:0]      quo_ff, quo_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0][7:0]  mid_ff, mid_in;
   logic [2:0][7:0]  left_ff, left_in;
   logic [2:0][7:0]  right_ff, right_in;
   logic             row_end_ff, row_end_in;
   logic             frame_end_ff, frame_end_in;

   logic                  csr_wr;
   dgbg_pkg::csr_index_type csr_idx;
   logic [HW-1:0]         h_eff;
   logic [EW-1:0]         rows_ext;
   logic                  last_col;
   logic                  last_row;
   logic [15:0]           c1;
   logic [15:0]           c2;
   logic                  diff_neg;
   logic [15:0]           diff_abs;
   logic [16:0]           div_t;
   logic                  div_ge;
   logic signed [17:0]    lerp_q;
   logic signed [17:0]    lerp_v;
   logic [7:0]            bev_v;
   dgbg_pkg::mul_req_type mul_req;
   logic [31:0]           mul_p;

   dgbg_mul u_mul (
      .clock   (clock),
      .req     (mul_req),
      .product (mul_p)
   );

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = dgbg_pkg::csr_index_type'(csr_paddr[4:3]);
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_idx)
         dgbg_pkg::CSR_START_COLOR: csr_prdata = 64'(start_color_ff);
         dgbg_pkg::CSR_END_COLOR:   csr_prdata = 64'(end_color_ff);
         dgbg_pkg::CSR_ROWS:        csr_prdata = 64'(rows_ff);
         dgbg_pkg::CSR_BEVEL_FLAGS: csr_prdata = 64'(flags_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // effective frame height
   always_comb begin
      rows_ext = EW'(rows_ff);
      if (rows_ff == '0) begin
         h_eff = HW'(1);
      end else if (rows_ext > EW'(MAX_ROWS)) begin
         h_eff = HW'(MAX_ROWS);
      end else begin
         h_eff = HW'(rows_ext);
      end
   end

   assign last_col = (column_ff == CW'(ROW_PIXELS - 1));
   assign last_row = (HW'(row_ff) == h_eff - HW'(1));

   assign c1       = start_color_ff[16*ch_ff +: 16];
   assign c2       = end_color_ff[16*ch_ff +: 16];
   assign diff_neg = (c2 < c1);
   assign diff_abs = diff_neg ? (c1 - c2) : (c2 - c1);

   // one restoring divide step
   assign div_t  = {rem_ff, quo_ff[15]};
   assign div_ge = (div_t >= 17'(h_eff));

   assign lerp_q = diff_neg ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff});
   assign lerp_v = $signed({2'b00, c1}) + lerp_q;

   always_comb begin
      mul_req = '{a: noise_ff, b: dgbg_pkg::LCG_MUL, c: dgbg_pkg::LCG_ADD};
      case (state_ff)
         dgbg_pkg::ST_LMUL:   mul_req = '{a: 32'(diff_abs), b: 32'(row_ff), c: 32'd0};
         dgbg_pkg::ST_RISSUE,
         dgbg_pkg::ST_DONE:   mul_req = '{a: rnoise_ff, b: dgbg_pkg::LCG_MUL,
                                          c: dgbg_pkg::LCG_ADD};
         default:             mul_req = '{a: noise_ff, b: dgbg_pkg::LCG_MUL,
                                          c: dgbg_pkg::LCG_ADD};
      endcase
   end

   always_comb begin
      start_color_in = start_color_ff;
      end_color_in   = end_color_ff;
      rows_in        = rows_ff;
      flags_in       = flags_ff;
      state_in       = state_ff;
      ch_in          = ch_ff;
      cnt_in         = cnt_ff;
      column_in      = column_ff;
      row_in         = row_ff;
      noise_in       = noise_ff;
      rnoise_in      = rnoise_ff;
      chan_in        = chan_ff;
      byte_in        = byte_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      mid_in         = mid_ff;
      left_in        = left_ff;
      right_in       = right_ff;
      row_end_in     = row_end_ff;
      frame_end_in   = frame_end_ff;
      bev_v          = '0;

      if (csr_wr) begin
         case (csr_idx)
            dgbg_pkg::CSR_START_COLOR: start_color_in = csr_pwdata[47:0];
            dgbg_pkg::CSR_END_COLOR:   end_color_in   = csr_pwdata[47:0];
            dgbg_pkg::CSR_ROWS:        rows_in        = csr_pwdata[10:0];
            dgbg_pkg::CSR_BEVEL_FLAGS: flags_in       = csr_pwdata[3:0];
            default:                   flags_in       = flags_ff;
         endcase
      end

      case (state_ff)
         dgbg_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_frame_start) begin
                  row_in    = '0;
                  column_in = '0;
                  noise_in  = req_seed;
                  rnoise_in = '0;
               end
               state_in = dgbg_pkg::ST_START;
            end
         end
         dgbg_pkg::ST_START: begin
            ch_in = '0;
            if (column_ff == '0) begin
               if (HW'(row_ff) >= h_eff) begin
                  row_in = '0;
               end
               state_in = dgbg_pkg::ST_LMUL;
            end else begin
               state_in = dgbg_pkg::ST_DISSUE;
            end
         end
         dgbg_pkg::ST_LMUL: begin
            state_in = dgbg_pkg::ST_LDIVINI;
         end
         dgbg_pkg::ST_LDIVINI: begin
            rem_in   = mul_p[31:16];
            quo_in   = mul_p[15:0];
            cnt_in   = '0;
            state_in = dgbg_pkg::ST_LDIV;
         end
         dgbg_pkg::ST_LDIV: begin
            rem_in = div_ge ? 16'(div_t - 17'(h_eff)) : div_t[15:0];
            quo_in = {quo_ff[14:0], div_ge};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = dgbg_pkg::ST_LSTORE;
            end
         end
         dgbg_pkg::ST_LSTORE: begin
            if (lerp_v < 0) begin
               chan_in[ch_ff] = 16'h0000;
            end else if (lerp_v > 18'sd65535) begin
               chan_in[ch_ff] = 16'hffff;
            end else begin
               chan_in[ch_ff] = lerp_v[15:0];
            end
            if (ch_ff == 2'd2) begin
               ch_in    = '0;
               state_in = dgbg_pkg::ST_DISSUE;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = dgbg_pkg::ST_LMUL;
            end
         end
         dgbg_pkg::ST_DISSUE: begin
            state_in = dgbg_pkg::ST_DWB;
         end
         dgbg_pkg::ST_DWB: begin
            noise_in       = mul_p;
            byte_in[ch_ff] = dgbg_pkg::dither_byte(chan_ff[ch_ff], mul_p[7:0]);
            if (ch_ff == 2'd2) begin
               ch_in    = '0;
               state_in = last_col ? dgbg_pkg::ST_RISSUE : dgbg_pkg::ST_DONE;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = dgbg_pkg::ST_DISSUE;
            end
         end
         dgbg_pkg::ST_RISSUE: begin
            // row end: fold row noise into pixel noise, then step it
            noise_in = noise_ff ^ rnoise_ff;
            state_in = dgbg_pkg::ST_DONE;
         end
         dgbg_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               for (int i = 0; i < 3; i++) begin
                  bev_v = byte_ff[i];
                  if (flags_ff[dgbg_pkg::FLAG_TOP] && row_ff == '0) begin
                     bev_v = dgbg_pkg::sat_add(bev_v);
                  end
                  if (flags_ff[dgbg_pkg::FLAG_BOTTOM] && last_row) begin
                     bev_v = dgbg_pkg::sat_sub(bev_v);
                  end
                  mid_in[i]   = bev_v;
                  left_in[i]  = (flags_ff[dgbg_pkg::FLAG_LEFT] && column_ff == '0) ?
                                dgbg_pkg::sat_add(bev_v) : bev_v;
                  right_in[i] = (flags_ff[dgbg_pkg::FLAG_RIGHT] && last_col) ?
                                dgbg_pkg::sat_sub(bev_v) : bev_v;
               end
               row_end_in   = last_col;
               frame_end_in = last_col && last_row;
               rsp_valid_in = 1'b1;
               if (last_col) begin
                  rnoise_in = mul_p;
                  column_in = '0;
                  row_in    = last_row ? '0 : row_ff + RW'(1);
               end else begin
                  column_in = column_ff + CW'(1);
               end
               state_in = dgbg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dgbg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_color_ff <= '0;
         end_color_ff   <= '0;
         rows_ff        <= dgbg_pkg::ROWS_RESET;
         flags_ff       <= '0;
         state_ff       <= dgbg_pkg::ST_IDLE;
         ch_ff          <= '0;
         cnt_ff         <= '0;
         column_ff      <= '0;
         row_ff         <= '0;
         noise_ff       <= '0;
         rnoise_ff      <= '0;
         chan_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         start_color_ff <= start_color_in;
         end_color_ff   <= end_color_in;
         rows_ff        <= rows_in;
         flags_ff       <= flags_in;
         state_ff       <= state_in;
         ch_ff          <= ch_in;
         cnt_ff         <= cnt_in;
         column_ff      <= column_in;
         row_ff         <= row_in;
         noise_ff       <= noise_in;
         rnoise_ff      <= rnoise_in;
         chan_ff        <= chan_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      mid_ff       <= mid_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      row_end_ff   <= row_end_in;
      frame_end_ff <= frame_end_in;
   end

   assign req_stall       = (state_ff != dgbg_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mid_blue    = mid_ff[0];
   assign rsp_mid_green   = mid_ff[1];
   assign rsp_mid_red     = mid_ff[2];
   assign rsp_left_blue   = left_ff[0];
   assign rsp_left_green  = left_ff[1];
   assign rsp_left_red    = left_ff[2];
   assign rsp_right_blue  = right_ff[0];
   assign rsp_right_green = right_ff[1];
   assign rsp_right_red   = right_ff[2];
   assign rsp_row_end     = row_end_ff;
   assign rsp_frame_end   = frame_end_ff;

   `DGBG_ASSERT_NXT(a_accept_starts, clock, reset, req_valid && !req_stall,
                    state_ff == dgbg_pkg::ST_START)
   `DGBG_ASSERT_IMP(a_div_rem_below_h, clock, reset, state_ff == dgbg_pkg::ST_LDIV,
                    17'(rem_ff) < 17'(h_eff))
   `DGBG_ASSERT_IMP(a_frame_end_on_row_end, clock, reset, rsp_valid_ff && frame_end_ff,
                    row_end_ff)
   `DGBG_ASSERT_NXT(a_done_holds_while_stalled, clock, reset,
                    state_ff == dgbg_pkg::ST_DONE && rsp_valid_ff && rsp_stall,
                    state_ff == dgbg_pkg::ST_DONE)

endmodule
